[rtl/assert_macros.svh]
// Assertion macros used by the cursor engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tcce_pkg.sv]
// Types and constants of the text console cursor engine.
package tcce_pkg;

    localparam int OFFSET_W = 11;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = 16;

    localparam logic [CHAR_W-1:0] CH_BELL  = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        OP_READ,
        OP_NOP,
        OP_BS,
        OP_LF,
        OP_CR,
        OP_TAB,
        OP_PUT
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [CHAR_W-1:0]   char_code;
        logic [OFFSET_W-1:0] read_offset;
    } cmd_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] cursor_offset;
        logic [CELL_W-1:0]   cell_data;
        logic                scrolled;
    } result_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

[rtl/tcce_ram.sv]
// Generic simple dual-port RAM with registered read.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tcce_fifo.sv]
// Small first-word-fall-through queue.
module tcce_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/tcce_front.sv]
// Front end: accepts input words, classifies them and queues commands.
module tcce_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           cmd,
    input  logic [7:0]                     char_code,
    input  logic [10:0]                    read_offset,
    input  tcce_pkg::back_status_t         status,
    input  logic                           cq_pop,
    output logic                           cq_empty,
    output tcce_pkg::cmd_item_t            cq_item
);
    import tcce_pkg::*;

    cmd_item_t item;
    logic      q_full;
    logic      q_push;

    always_comb
    begin
        item.char_code   = char_code;
        item.read_offset = read_offset;
        if (cmd == CMD_READ)
        begin
            item.op = OP_READ;
        end
        else
        begin
            unique case (char_code)
                CH_BELL: item.op = OP_NOP;
                CH_BS:   item.op = OP_BS;
                CH_LF:   item.op = OP_LF;
                CH_CR:   item.op = OP_CR;
                CH_TAB:  item.op = OP_TAB;
                default: item.op = OP_PUT;
            endcase
        end
    end

    // no words taken while the screen is being cleared
    assign full   = q_full || status.init_busy;
    assign q_push = push && !full;

    tcce_fifo #(
        .WIDTH($bits(cmd_item_t)),
        .DEPTH(2)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .wdata(item),
        .full (q_full),
        .pop  (cq_pop),
        .rdata(cq_item),
        .empty(cq_empty)
    );

endmodule

[rtl/tcce_back.sv]
// Back end: cursor state, screen RAM, scroll and result generation.
module tcce_back #(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    input  logic                   cq_empty,
    input  tcce_pkg::cmd_item_t    cq_item,
    output logic                   cq_pop,
    input  logic                   rq_full,
    output logic                   rq_push,
    output tcce_pkg::result_t      rq_wdata,
    output tcce_pkg::back_status_t status
);
    import tcce_pkg::*;

    localparam int CELLS      = ROWS * COLS;
    localparam int AW         = $clog2(CELLS);
    localparam int RW         = $clog2(ROWS);
    localparam int CLW        = $clog2(COLS);
    localparam int NW         = $clog2(COLS + TAB_STOP + 1);
    localparam int TW         = $clog2(TAB_STOP + 1);
    localparam int LAST_PHASE = (COLS - 1) % TAB_STOP;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_REPORT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CLW-1:0]    col_reg, col_next;
    logic [TW-1:0]     phase_reg, phase_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [AW-1:0]     blank_base_reg, blank_base_next;
    logic [AW-1:0]     lin_reg;
    logic [ATTR_W-1:0] attr_reg;
    cmd_item_t         item_reg, item_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              scrolled_reg, scrolled_next;

    logic [AW-1:0]     cur_lin;
    logic [AW:0]       wr_sum, rd_sum, base_adv;
    logic [AW-1:0]     wr_phys, rd_phys;
    logic              rd_in_range;
    logic [NW-1:0]     inc_col, tab_col;
    logic              wrap;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    assign cur_lin = AW'(row_reg) * AW'(COLS) + AW'(col_reg);

    // logical to physical through the rotating row base
    assign wr_sum  = (AW + 1)'(lin_reg) + (AW + 1)'(base_reg);
    assign wr_phys = (wr_sum >= (AW + 1)'(CELLS)) ? AW'(wr_sum - (AW + 1)'(CELLS))
                                                  : AW'(wr_sum);
    assign rd_in_range = (32'(item_reg.read_offset) < 32'(CELLS));
    assign rd_sum  = (AW + 1)'(AW'(item_reg.read_offset)) + (AW + 1)'(base_reg);
    assign rd_phys = (rd_sum >= (AW + 1)'(CELLS)) ? AW'(rd_sum - (AW + 1)'(CELLS))
                                                  : AW'(rd_sum);
    assign base_adv = (AW + 1)'(base_reg) + (AW + 1)'(COLS);

    assign inc_col = NW'(col_reg) + NW'(1);
    assign tab_col = NW'(col_reg) + NW'(TAB_STOP) - NW'(phase_reg);

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        phase_next      = phase_reg;
        base_next       = base_reg;
        sweep_next      = sweep_reg;
        blank_base_next = blank_base_reg;
        item_next       = item_reg;
        cell_next       = cell_reg;
        scrolled_next   = scrolled_reg;
        wrap            = 1'b0;
        cq_pop          = 1'b0;
        rq_push         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wr_phys;
        ram_wdata       = {attr_reg, item_reg.char_code};

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = {RESET_ATTR, CH_SPACE};
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (!cq_empty)
                begin
                    cq_pop        = 1'b1;
                    item_next     = cq_item;
                    cell_next     = '0;
                    scrolled_next = 1'b0;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_REPORT;
                unique case (item_reg.op)
                    OP_READ:
                    begin
                        if (rd_in_range)
                        begin
                            state_next = S_RDWAIT;
                        end
                    end
                    OP_NOP:
                    begin
                    end
                    OP_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next   = col_reg - CLW'(1);
                            phase_next = (phase_reg == '0) ? TW'(TAB_STOP - 1)
                                                           : phase_reg - TW'(1);
                        end
                        else if (row_reg != '0)
                        begin
                            col_next   = CLW'(COLS - 1);
                            phase_next = TW'(LAST_PHASE);
                            row_next   = row_reg - RW'(1);
                        end
                    end
                    OP_LF:
                    begin
                        col_next   = '0;
                        phase_next = '0;
                        wrap       = 1'b1;
                    end
                    OP_CR:
                    begin
                        col_next   = '0;
                        phase_next = '0;
                    end
                    OP_TAB:
                    begin
                        phase_next = '0;
                        if (tab_col >= NW'(COLS))
                        begin
                            col_next = '0;
                            wrap     = 1'b1;
                        end
                        else
                        begin
                            col_next = CLW'(tab_col);
                        end
                    end
                    OP_PUT:
                    begin
                        ram_we = 1'b1;
                        if (inc_col == NW'(COLS))
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            wrap       = 1'b1;
                        end
                        else
                        begin
                            col_next   = CLW'(inc_col);
                            phase_next = (phase_reg == TW'(TAB_STOP - 1)) ? '0
                                                                          : phase_reg + TW'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (wrap)
                begin
                    if (row_reg == RW'(ROWS - 1))
                    begin
                        // old top row becomes the new bottom row
                        base_next       = (base_adv == (AW + 1)'(CELLS)) ? '0 : AW'(base_adv);
                        blank_base_next = base_reg;
                        sweep_next      = '0;
                        scrolled_next   = 1'b1;
                        state_next      = S_BLANK;
                    end
                    else
                    begin
                        row_next = row_reg + RW'(1);
                    end
                end
            end
            S_RDWAIT:
            begin
                cell_next  = ram_rdata;
                state_next = S_REPORT;
            end
            S_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = blank_base_reg + sweep_reg;
                ram_wdata = {attr_reg, CH_SPACE};
                if (sweep_reg == AW'(COLS - 1))
                begin
                    sweep_next = '0;
                    state_next = S_REPORT;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            S_REPORT:
            begin
                if (!rq_full)
                begin
                    rq_push    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rq_wdata.cursor_offset = OFFSET_W'(cur_lin);
    assign rq_wdata.cell_data     = cell_reg;
    assign rq_wdata.scrolled      = scrolled_reg;
    assign status.init_busy       = (state_reg == S_INIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            row_reg        <= '0;
            col_reg        <= '0;
            phase_reg      <= '0;
            base_reg       <= '0;
            sweep_reg      <= '0;
            blank_base_reg <= '0;
            attr_reg       <= RESET_ATTR;
            scrolled_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            phase_reg      <= phase_next;
            base_reg       <= base_next;
            sweep_reg      <= sweep_next;
            blank_base_reg <= blank_base_next;
            scrolled_reg   <= scrolled_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cell_reg <= cell_next;
        lin_reg  <= cur_lin;
    end

    tcce_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_screen (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_phys),
        .rdata(ram_rdata)
    );

endmodule

[rtl/text_console_cursor_engine_top.sv]
// Top level of the text console cursor engine.
// In the back-end sequencer a word passes the states take, execute and report; a
// read inside the screen adds a wait state for the screen RAM's registered read
// port, a read past the last cell takes the same path as a put.
// A put, line feed or tab that scrolls adds a blanking pass: scrolling rotates a
// row base pointer and the single RAM write port blanks the new bottom row one
// cell a cycle with the current attribute. After reset a clearing pass blanks
// every cell (space, attribute 7); full stays high until it ends. A two-word
// command queue and a two-word result queue let input and output stall apart.
`include "assert_macros.svh"

module text_console_cursor_engine_top #(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic [7:0]  char_code,
    input  logic [10:0] read_offset,
    output logic        empty,
    input  logic        pop,
    output logic [10:0] cursor_offset,
    output logic [15:0] cell_data,
    output logic        scrolled,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import tcce_pkg::*;

    back_status_t status;
    cmd_item_t    cq_item;
    logic         cq_pop, cq_empty;
    result_t      res_word, out_word;
    logic         res_push, res_full;

    tcce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .char_code  (char_code),
        .read_offset(read_offset),
        .status     (status),
        .cq_pop     (cq_pop),
        .cq_empty   (cq_empty),
        .cq_item    (cq_item)
    );

    tcce_back #(
        .COLS    (COLS),
        .ROWS    (ROWS),
        .TAB_STOP(TAB_STOP)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cq_empty (cq_empty),
        .cq_item  (cq_item),
        .cq_pop   (cq_pop),
        .rq_full  (res_full),
        .rq_push  (res_push),
        .rq_wdata (res_word),
        .status   (status)
    );

    tcce_fifo #(
        .WIDTH($bits(result_t)),
        .DEPTH(2)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res_word),
        .full (res_full),
        .pop  (pop),
        .rdata(out_word),
        .empty(empty)
    );

    assign cursor_offset = out_word.cursor_offset;
    assign cell_data     = out_word.cell_data;
    assign scrolled      = out_word.scrolled;

    `ASSERT_IMPLIES(a_init_blocks_input, clk, rst_n,
        status.init_busy, full, "input open during clear")
    `ASSERT_IMPLIES(a_init_no_result, clk, rst_n,
        status.init_busy, !res_push, "result during clear")
    `ASSERT_IMPLIES(a_push_room, clk, rst_n,
        res_push, !res_full, "result pushed into full queue")
    `ASSERT_IMPLIES(a_scroll_is_put, clk, rst_n,
        res_push && res_word.scrolled, res_word.cell_data == '0, "scroll with cell data")
    `ASSERT_NEXT(a_push_visible, clk, rst_n,
        res_push, !empty, "pushed result not visible")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the text console cursor engine: directed and random words.
module testbench;
    import tcce_pkg::*;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int TAB_STOP    = 8;
    localparam int CELLS       = ROWS * COLS;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        cmd;
    logic [7:0]  char_code;
    logic [10:0] read_offset;
    logic        empty;
    logic        pop;
    logic [10:0] cursor_offset;
    logic [15:0] cell_data;
    logic        scrolled;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    bit          no_idle = 1'b0;
    int unsigned cycles  = 0;

    class console_scoreboard;
        logic [7:0]  attr;
        int unsigned row;
        int unsigned col;
        logic [15:0] cells [CELLS];
        result_t     pending [$];
        int          errors;

        function new();
            attr   = RESET_ATTR;
            row    = 0;
            col    = 0;
            errors = 0;
            foreach (cells[i]) cells[i] = {RESET_ATTR, CH_SPACE};
        endfunction

        function void set_attr(logic [7:0] a);
            attr = a;
        endfunction

        function int unsigned cursor_pos();
            return row * COLS + col;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // Moves down one row; scrolls at the bottom and returns 1 if it did.
        function logic line_down();
            if (row >= ROWS - 1) begin
                row = ROWS - 1;
                for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
                for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
                return 1'b1;
            end
            row++;
            return 1'b0;
        endfunction

        function void note_input(logic c, logic [7:0] ch, logic [10:0] ro);
            result_t r;
            r.cell_data = '0;
            r.scrolled  = 1'b0;
            if (c == CMD_READ) begin
                if (ro < CELLS) r.cell_data = cells[ro];
            end else begin
                case (ch)
                    CH_BELL: ;
                    CH_BS:
                    begin
                        if (col > 0) col--;
                        else if (row > 0)
                        begin
                            col = COLS - 1;
                            row--;
                        end
                    end
                    CH_LF:
                    begin
                        r.scrolled = line_down();
                        col = 0;
                    end
                    CH_CR: col = 0;
                    CH_TAB:
                    begin
                        col = (col / TAB_STOP + 1) * TAB_STOP;
                        if (col >= COLS)
                        begin
                            col = 0;
                            r.scrolled = line_down();
                        end
                    end
                    default:
                    begin
                        cells[row * COLS + col] = {attr, ch};
                        col++;
                        if (col >= COLS)
                        begin
                            col = 0;
                            r.scrolled = line_down();
                        end
                    end
                endcase
            end
            r.cursor_offset = 11'(row * COLS + col);
            pending.push_back(r);
        endfunction

        function void check_result(logic [10:0] off, logic [15:0] cd, logic s);
            result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word: cursor_offset %0d cell_data %h scrolled %0b",
                         $time, off, cd, s);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (off !== e.cursor_offset) begin
                $display("%0t: cursor_offset expected %0d actual %0d",
                         $time, e.cursor_offset, off);
                errors++;
            end
            if (cd !== e.cell_data) begin
                $display("%0t: cell_data expected %h actual %h", $time, e.cell_data, cd);
                errors++;
            end
            if (s !== e.scrolled) begin
                $display("%0t: scrolled expected %0b actual %0b", $time, e.scrolled, s);
                errors++;
            end
        endfunction
    endclass

    console_scoreboard sb;

    text_console_cursor_engine_top #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .char_code     (char_code),
        .read_offset   (read_offset),
        .empty         (empty),
        .pop           (pop),
        .cursor_offset (cursor_offset),
        .cell_data     (cell_data),
        .scrolled      (scrolled),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Result side: pops with random stalls, checks at the rising edge.
    initial
    begin
        pop = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            pop <= no_idle || ($urandom_range(99) >= 13);
            @(posedge clk);
            if (pop && !empty) sb.check_result(cursor_offset, cell_data, scrolled);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic c, input logic [7:0] ch, input logic [10:0] ro);
        while (!no_idle && $urandom_range(99) < 13)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push        <= 1'b1;
        cmd         <= c;
        char_code   <= ch;
        read_offset <= ro;
        do @(posedge clk); while (full);
        sb.note_input(c, ch, ro);
        @(negedge clk);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_word(CMD_PUT, ch, 11'($urandom_range(2047)));
    endtask

    task automatic read_cell(input logic [10:0] ro);
        send_word(CMD_READ, 8'($urandom_range(255)), ro);
    endtask

    task automatic write_attr(input logic [7:0] a);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge clk);
        sb.set_attr(a);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
    endtask

    task automatic random_word();
        int unsigned sel;
        int          near;
        sel = $urandom_range(99);
        if (sel < 10)
        begin
            near = int'(sb.cursor_pos()) - int'($urandom_range(160));
            read_cell(11'((near < 0) ? 0 : near));
        end
        else if (sel < 17) read_cell(11'($urandom_range(CELLS - 1)));
        else if (sel < 20) read_cell(11'($urandom_range(2047)));
        else if (sel < 30) put_char(CH_LF);
        else if (sel < 36) put_char(CH_TAB);
        else if (sel < 42) put_char(CH_BS);
        else if (sel < 45) put_char(CH_CR);
        else if (sel < 47) put_char(CH_BELL);
        else put_char(8'($urandom_range(255)));
    endtask

    initial
    begin
        logic [7:0] attr_val;
        push        = 1'b0;
        cmd         = CMD_PUT;
        char_code   = '0;
        read_offset = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        rst_n       = 1'b0;
        sb          = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        do @(negedge clk); while (full);
        write_attr(8'h1E);

        put_char(CH_BS);            // backspace at origin
        send_word(CMD_READ, 8'hFF, 11'd0);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_BELL);
        put_char(CH_BS);
        put_char(CH_CR);
        put_char(CH_LF);
        put_char(CH_BS);            // back to the end of the row above
        put_char(8'h41);            // last column, wraps
        read_cell(11'd79);
        read_cell(11'(CELLS - 1));
        read_cell(11'(CELLS));
        read_cell(11'd2047);
        repeat (10) put_char(CH_TAB);

        for (int p = 0; p < 5; p++)
        begin
            drain();
            case (p)
                0: attr_val = 8'h00;
                1: attr_val = 8'hFF;
                3: attr_val = 8'h70;
                default: attr_val = 8'($urandom_range(255));
            endcase
            write_attr(attr_val);
            no_idle = (p == 2);
            repeat (220) random_word();
        end
        no_idle = 1'b0;
        drain();
        repeat (200) @(negedge clk);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_fifo.sv
rtl/tcce_front.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine_top.sv
verif/testbench.sv
